// ----- rtl/rptr_pkg.sv -----
// shared types, constants and helpers for the rate pid torque regulator
// no dependencies; imported by every module of the block
package rptr_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int DtW      = 31;
  localparam int MulW     = DataW + 1;
  localparam int ProdW    = 2 * DataW;
  localparam int ShW      = ProdW - FracBits;
  localparam int SatW     = ShW + 2;
  localparam int DivW     = DataW + 1 + FracBits;
  localparam int DivCntW  = $clog2(DivW);

  localparam logic signed [DataW-1:0] InertiaRst = DataW'(1) << FracBits;
  localparam logic [DtW-1:0] DtMinRst = DtW'(66);
  localparam logic [DtW-1:0] DtMaxRst = DtW'(6554);

  localparam logic signed [SatW-1:0] SatMax = {{(SatW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
  localparam logic signed [SatW-1:0] SatMin = {{(SatW-DataW+1){1'b1}}, {(DataW-1){1'b0}}};

  typedef enum logic [2:0] {
    CFG_P_GAIN    = 3'd0,
    CFG_I_GAIN    = 3'd1,
    CFG_D_GAIN    = 3'd2,
    CFG_INT_LIMIT = 3'd3,
    CFG_DAMPING   = 3'd4,
    CFG_INERTIA   = 3'd5,
    CFG_DT_MIN    = 3'd6,
    CFG_DT_MAX    = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    OP_STEP = 1'b0,
    OP_LOAD = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_RAISED  = 2'd1,
    STS_LOWERED = 2'd2
  } status_e;

  // request from the sequencer to the divider
  typedef struct packed {
    logic            start;
    logic            neg;
    logic [DivW-1:0] mag;
    logic [DtW-1:0]  divisor;
  } div_req_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [SatW-1:0] x);
    logic signed [DataW-1:0] r;
    if (x > SatMax) begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end else if (x < SatMin) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

  // drop the fraction bits of a product, rounding towards minus infinity
  function automatic logic signed [ShW-1:0] asr(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s = p >>> FracBits;
    return s[ShW-1:0];
  endfunction

endpackage

// ----- rtl/rptr_mul.sv -----
// shared signed multiplier with a registered product
// depends on rptr_pkg
module rptr_mul import rptr_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [MulW-1:0]  a_i,
  input  logic signed [MulW-1:0]  b_i,
  output logic signed [ProdW-1:0] p_o
);

  logic signed [2*MulW-1:0] prod;
  logic signed [ProdW-1:0]  p_q;

  // operands stay in range so the product fits the narrower result
  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= prod[ProdW-1:0];
  end

  assign p_o = p_q;

endmodule

// ----- rtl/rptr_div.sv -----
// restoring divider, one quotient bit per cycle, with signed saturation of the result
// depends on rptr_pkg
module rptr_div import rptr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_req_t                req_i,
  output logic                    busy_o,
  output logic signed [DataW-1:0] quot_o
);

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DtW-1:0]     rem_q;
  logic [DivW-1:0]    quo_q;
  logic [DtW-1:0]     dsr_q;
  logic               neg_q;

  logic [DtW:0]       rem_sh;
  logic               ge;
  logic [DtW:0]       rem_sub;
  logic               ovf_pos;
  logic               ovf_neg;
  logic [DataW-1:0]   quo_neg;

  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.mag;
      dsr_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DtW-1:0] : rem_sh[DtW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  // magnitude beyond the 32-bit range saturates
  assign ovf_pos = |quo_q[DivW-1:DataW-1];
  assign ovf_neg = (|quo_q[DivW-1:DataW]) || (quo_q[DataW-1] && (|quo_q[DataW-2:0]));
  assign quo_neg = -quo_q[DataW-1:0];

  always_comb begin
    if (neg_q) begin
      quot_o = ovf_neg ? {1'b1, {(DataW-1){1'b0}}} : quo_neg;
    end else begin
      quot_o = ovf_pos ? {1'b0, {(DataW-1){1'b1}}} : quo_q[DataW-1:0];
    end
  end

  assign busy_o = busy_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= DivCntW'(DivW - 1)))
    else $error("divider step count out of range");

  a_rem_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dsr_q))
    else $error("divider remainder not below divisor");

  a_start_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (req_i.divisor != '0))
    else $error("divider started with zero divisor");

endmodule

// ----- rtl/rate_pid_torque_regulator.sv -----
// Rate PID torque regulator with damping feed-forward, signed Q16.16 throughout.
// A step word runs the derivative division, one quotient bit per cycle over
// 49 bits, while the six products share one registered multiplier alongside
// it. A new word is taken once the sequencer is back in idle, which it
// reaches while the previous result may still wait on the output.
module rate_pid_torque_regulator import rptr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // target_rate[31:0], measured_rate[63:32], delta_time[94:64],
  // integrator_load[126:95], zero fill [127]
  input  logic [127:0] s_axis_tdata,
  // opcode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // torque_demand[31:0], integrator_value[63:32], status[65:64], zero fill [71:66]
  output logic [71:0]  m_axis_tdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIFF, ST_INTEG, ST_MP, ST_MI, ST_MF,
    ST_DWAIT, ST_MD, ST_MT, ST_MFIN, ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic signed [DataW-1:0] p_gain_q, i_gain_q, d_gain_q, damping_q, inertia_q;
  logic [DtW-1:0]          int_lim_q, dt_min_q, dt_max_q;

  // regulator state
  logic signed [DataW-1:0] integrator_q, prev_err_q;

  // working registers
  logic signed [DataW-1:0] tgt_q, meas_q, load_q, err_q, torque_q;
  logic [DtW-1:0]          dt_q;
  logic                    is_load_q;
  status_e                 status_q;
  logic signed [SatW-1:0]  acc_q;
  logic signed [ShW-1:0]   ff_q;

  logic        out_valid_q;
  logic [71:0] out_data_q;

  // shared units
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [ShW-1:0]   prod_sh;
  div_req_t                div_req;
  logic                    div_busy;
  logic signed [DataW-1:0] div_quot;

  logic                    in_acc;
  logic                    out_free;
  logic signed [DataW:0]   err_wide;
  logic signed [DataW:0]   diff;
  logic [DataW:0]          diff_mag;
  logic [DtW-1:0]          dt_lo, dt_hi, dt_clamp;
  status_e                 sts_lo, sts_hi;
  logic signed [ShW:0]     integ_sum, lim_pos, lim_neg, integ_cl;
  logic signed [DataW-1:0] acc_sat;

  rptr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  rptr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign prod_sh       = asr(prod);

  // time step clamp: raise to minimum, then lower to maximum, never zero
  always_comb begin
    dt_lo  = dt_q;
    sts_lo = STS_OK;
    if (dt_q < dt_min_q) begin
      dt_lo  = dt_min_q;
      sts_lo = STS_RAISED;
    end
    dt_hi  = dt_lo;
    sts_hi = sts_lo;
    if (dt_lo > dt_max_q) begin
      dt_hi  = dt_max_q;
      sts_hi = STS_LOWERED;
    end
    dt_clamp = (dt_hi == '0) ? DtW'(1) : dt_hi;
  end

  assign err_wide = {tgt_q[DataW-1], tgt_q} - {meas_q[DataW-1], meas_q};
  assign diff     = {err_q[DataW-1], err_q} - {prev_err_q[DataW-1], prev_err_q};
  assign diff_mag = diff[DataW] ? (DataW+1)'(-diff) : diff;

  always_comb begin
    div_req.start   = (state_q == ST_DIFF);
    div_req.neg     = diff[DataW];
    div_req.mag     = {diff_mag, {FracBits{1'b0}}};
    div_req.divisor = dt_q;
  end

  // integrator update with symmetric clamp
  assign integ_sum = (ShW+1)'(integrator_q) + (ShW+1)'(prod_sh);
  assign lim_pos   = signed'({{(ShW+1-DtW){1'b0}}, int_lim_q});
  assign lim_neg   = -lim_pos;

  always_comb begin
    integ_cl = integ_sum;
    if (integ_sum > lim_pos) begin
      integ_cl = lim_pos;
    end
    if (integ_cl < lim_neg) begin
      integ_cl = lim_neg;
    end
  end

  assign acc_sat = sat32(acc_q);

  // multiplier operand select, product is read one state later
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_DIFF: begin
        mul_a = MulW'(err_q);
        mul_b = signed'({2'b00, dt_q});
      end
      ST_INTEG: begin
        mul_a = MulW'(p_gain_q);
        mul_b = MulW'(err_q);
      end
      ST_MP: begin
        mul_a = MulW'(i_gain_q);
        mul_b = MulW'(integrator_q);
      end
      ST_MI: begin
        mul_a = MulW'(damping_q);
        mul_b = -MulW'(tgt_q);
      end
      ST_DWAIT: begin
        mul_a = MulW'(d_gain_q);
        mul_b = MulW'(div_quot);
      end
      ST_MT: begin
        mul_a = MulW'(inertia_q);
        mul_b = MulW'(acc_sat);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_gain_q  <= '0;
      i_gain_q  <= '0;
      d_gain_q  <= '0;
      int_lim_q <= '0;
      damping_q <= '0;
      inertia_q <= InertiaRst;
      dt_min_q  <= DtMinRst;
      dt_max_q  <= DtMaxRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_P_GAIN:    p_gain_q  <= cfg_data_i;
        CFG_I_GAIN:    i_gain_q  <= cfg_data_i;
        CFG_D_GAIN:    d_gain_q  <= cfg_data_i;
        CFG_INT_LIMIT: int_lim_q <= cfg_data_i[DtW-1:0];
        CFG_DAMPING:   damping_q <= cfg_data_i;
        CFG_INERTIA:   inertia_q <= cfg_data_i;
        CFG_DT_MIN:    dt_min_q  <= cfg_data_i[DtW-1:0];
        CFG_DT_MAX:    dt_max_q  <= cfg_data_i[DtW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      integrator_q <= '0;
      prev_err_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (opcode_e'(s_axis_tuser) == OP_LOAD) begin
              integrator_q <= s_axis_tdata[126:95];
              state_q      <= ST_DONE;
            end else begin
              state_q <= ST_PREP;
            end
          end
        end
        ST_PREP:  state_q <= ST_DIFF;
        ST_DIFF:  state_q <= ST_INTEG;
        ST_INTEG: begin
          integrator_q <= integ_cl[DataW-1:0];
          state_q      <= ST_MP;
        end
        ST_MP:    state_q <= ST_MI;
        ST_MI:    state_q <= ST_MF;
        ST_MF:    state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (!div_busy) begin
            state_q <= ST_MD;
          end
        end
        ST_MD:    state_q <= ST_MT;
        ST_MT:    state_q <= ST_MFIN;
        ST_MFIN: begin
          prev_err_q <= err_q;
          state_q    <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          tgt_q     <= s_axis_tdata[31:0];
          meas_q    <= s_axis_tdata[63:32];
          dt_q      <= s_axis_tdata[94:64];
          load_q    <= s_axis_tdata[126:95];
          is_load_q <= s_axis_tuser;
          torque_q  <= '0;
          status_q  <= STS_OK;
        end
      end
      ST_PREP: begin
        dt_q     <= dt_clamp;
        status_q <= sts_hi;
        err_q    <= sat32(SatW'(err_wide));
      end
      ST_MP:  acc_q <= SatW'(prod_sh);
      ST_MI:  acc_q <= acc_q + SatW'(prod_sh);
      ST_MF:  ff_q  <= prod_sh;
      ST_MD:  acc_q <= acc_q + SatW'(prod_sh);
      ST_MFIN: torque_q <= sat32(SatW'(ff_q) + SatW'(prod_sh));
      ST_DONE: begin
        if (out_free) begin
          out_data_q <= {6'b0, status_q, integrator_q, torque_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_idle_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !div_busy)
    else $error("word accepted while divider busy");

  a_load_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free && is_load_q) |=>
      (m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[63:32] == load_q &&
       m_axis_tdata[65:64] == STS_OK))
    else $error("load result malformed");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[65:64] == STS_OK || m_axis_tdata[65:64] == STS_RAISED ||
                       m_axis_tdata[65:64] == STS_LOWERED))
    else $error("undefined status code");

  a_integ_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INTEG) |=>
      ($signed(integrator_q) <= $signed({1'b0, int_lim_q}) &&
       $signed(integrator_q) >= -$signed({1'b0, int_lim_q})))
    else $error("integrator outside limit after step");

endmodule
